[hw/rtl/unique_value_deque_top_assert.svh]
// Assertion macros shared by the unique value deque RTL.
`ifndef UNIQUE_VALUE_DEQUE_TOP_ASSERT_SVH
`define UNIQUE_VALUE_DEQUE_TOP_ASSERT_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define UVD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define UVD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/uvd_pkg.sv]
// Shared types and codes for the unique value deque.
`default_nettype none

package uvd_pkg;

   localparam int MODE_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_INS_BACK  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_REM_FRONT = 3'd2;
   localparam logic [MODE_W-1:0] MODE_REM_BACK  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd4;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                load;
      logic                scan_read;
      logic                insert;
      logic                rem_read;
      logic                rem_take;
      logic                clear;
      logic                set_status;
      logic [STATUS_W-1:0] status_code;
      logic                emit;
   } uvd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              count_zero;
      logic              count_full;
      logic              scan_last;
      logic              dup_found;
      logic              out_free;
   } uvd_stat_type;

endpackage

`default_nettype wire

[hw/rtl/uvd_channel_if.sv]
// Request and response channel interfaces of the unique value deque.
`default_nettype none

interface uvd_req_if;
   logic                                valid;
   logic                                ready;
   logic [uvd_pkg::MODE_W-1:0]          mode;
   logic signed [uvd_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output mode, output value, input ready);
   modport sink   (input valid, input mode, input value, output ready);
endinterface

interface uvd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [uvd_pkg::STATUS_W-1:0]        status;
   logic signed [uvd_pkg::VALUE_W-1:0]  removed_value;
   logic [uvd_pkg::COUNT_W-1:0]         entry_count;

   modport source (output valid, output status, output removed_value,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input removed_value,
                   input entry_count, output ready);
endinterface

`default_nettype wire

[hw/rtl/uvd_ram.sv]
// Generic simple dual port RAM with registered read.
`default_nettype none

module uvd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                               clock,
   input  wire logic                               wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                   wr_data,
   input  wire logic                               rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                   rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[hw/rtl/uvd_ctrl.sv]
// Controller state machine of the unique value deque.
`default_nettype none

module uvd_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire uvd_pkg::uvd_stat_type stat,
   output      uvd_pkg::uvd_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DECODE   = 3'd1;
   localparam logic [2:0] S_SCAN     = 3'd2;
   localparam logic [2:0] S_DRAIN    = 3'd3;
   localparam logic [2:0] S_INSERT   = 3'd4;
   localparam logic [2:0] S_REM_WAIT = 3'd5;
   localparam logic [2:0] S_FINISH   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            priority if (stat.mode == uvd_pkg::MODE_INS_FRONT ||
                         stat.mode == uvd_pkg::MODE_INS_BACK) begin
               // nothing stored means nothing to scan
               state_in = stat.count_zero ? S_INSERT : S_SCAN;
            end else if (stat.mode == uvd_pkg::MODE_REM_FRONT ||
                         stat.mode == uvd_pkg::MODE_REM_BACK) begin
               if (stat.count_zero) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = uvd_pkg::ST_EMPTY;
                  state_in        = S_FINISH;
               end else begin
                  cmd.rem_read = 1'b1;
                  state_in     = S_REM_WAIT;
               end
            end else if (stat.mode == uvd_pkg::MODE_CLEAR) begin
               cmd.clear = 1'b1;
               state_in  = S_FINISH;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SCAN: begin
            cmd.scan_read = 1'b1;
            if (stat.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            priority if (stat.dup_found) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = uvd_pkg::ST_DUP;
               state_in        = S_FINISH;
            end else if (stat.count_full) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = uvd_pkg::ST_FULL;
               state_in        = S_FINISH;
            end else begin
               state_in = S_INSERT;
            end
         end
         S_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = S_FINISH;
         end
         S_REM_WAIT: begin
            cmd.rem_take = 1'b1;
            state_in     = S_FINISH;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[hw/rtl/uvd_datapath.sv]
// Datapath of the unique value deque: ring pointers, entry RAM, scan and response register.
`default_nettype none
`include "unique_value_deque_top_assert.svh"

module uvd_datapath #(
   parameter int CAPACITY = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [uvd_pkg::MODE_W-1:0]          req_mode,
   input  wire logic [uvd_pkg::VALUE_W-1:0]         req_value,
   input  wire uvd_pkg::uvd_cmd_type                cmd,
   output      uvd_pkg::uvd_stat_type               stat,
   input  wire logic                                rsp_ready,
   output      logic                                rsp_valid,
   output      logic [uvd_pkg::STATUS_W-1:0]        rsp_status,
   output      logic [uvd_pkg::VALUE_W-1:0]         rsp_removed_value,
   output      logic [uvd_pkg::COUNT_W-1:0]         rsp_entry_count
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [IDX_W:0]   CAP_EXT = (IDX_W + 1)'(CAPACITY);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);
   localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(CAPACITY - 1);

   // (a + b) modulo CAPACITY for a, b below CAPACITY
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
      logic [IDX_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= CAP_EXT) begin
         sum = sum - CAP_EXT;
      end
      return sum[IDX_W-1:0];
   endfunction

   logic [uvd_pkg::MODE_W-1:0]   mode_ff;
   logic [uvd_pkg::VALUE_W-1:0]  value_ff;
   logic [IDX_W-1:0]             front_ff;
   logic [CNT_W-1:0]             count_ff;
   logic [IDX_W-1:0]             scan_ff;
   logic                         cmp_ff;
   logic                         hit_ff;
   logic [uvd_pkg::STATUS_W-1:0] status_ff;
   logic [uvd_pkg::VALUE_W-1:0]  removed_ff;
   logic                         rsp_valid_ff;
   logic [uvd_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [uvd_pkg::VALUE_W-1:0]  rsp_removed_ff;
   logic [uvd_pkg::COUNT_W-1:0]  rsp_count_ff;

   logic [CNT_W-1:0]             count_m1;
   logic [CNT_W-1:0]             scan_next_cnt;
   logic [IDX_W-1:0]             front_dec;
   logic [IDX_W-1:0]             front_inc;
   logic [IDX_W-1:0]             back_wr_addr;
   logic [IDX_W-1:0]             back_rd_addr;
   logic [IDX_W-1:0]             scan_addr;
   logic                         ram_we;
   logic [IDX_W-1:0]             ram_wr_addr;
   logic                         ram_re;
   logic [IDX_W-1:0]             ram_rd_addr;
   logic [uvd_pkg::VALUE_W-1:0]  ram_rd_data;
   logic                         match;
   logic                         ins_front;

   assign count_m1      = count_ff - CNT_W'(1);
   assign scan_next_cnt = CNT_W'(scan_ff) + CNT_W'(1);
   assign front_dec     = (front_ff == '0) ? IDX_TOP : (front_ff - IDX_ONE);
   assign front_inc     = ring_add(front_ff, IDX_ONE);
   assign back_wr_addr  = ring_add(front_ff, count_ff[IDX_W-1:0]);
   assign back_rd_addr  = ring_add(front_ff, count_m1[IDX_W-1:0]);
   assign scan_addr     = ring_add(front_ff, scan_ff);
   assign ins_front     = (mode_ff == uvd_pkg::MODE_INS_FRONT);

   assign ram_we      = cmd.insert;
   assign ram_wr_addr = ins_front ? front_dec : back_wr_addr;
   assign ram_re      = cmd.scan_read | cmd.rem_read;
   assign ram_rd_addr = cmd.scan_read ? scan_addr :
                        ((mode_ff == uvd_pkg::MODE_REM_FRONT) ? front_ff : back_rd_addr);

   uvd_ram #(
      .WIDTH (uvd_pkg::VALUE_W),
      .DEPTH (CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (value_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign match = cmp_ff & (ram_rd_data == value_ff);

   assign stat.mode       = mode_ff;
   assign stat.count_zero = (count_ff == '0);
   assign stat.count_full = (count_ff >= CAP_CNT);
   assign stat.scan_last  = (scan_next_cnt >= count_ff);
   assign stat.dup_found  = hit_ff | match;
   assign stat.out_free   = ~rsp_valid_ff | rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_mode;
         value_ff <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         scan_ff      <= '0;
         cmp_ff       <= 1'b0;
         hit_ff       <= 1'b0;
         status_ff    <= uvd_pkg::ST_DONE;
         removed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmp_ff <= cmd.scan_read;
         if (match) begin
            hit_ff <= 1'b1;
         end
         if (cmd.load) begin
            scan_ff    <= '0;
            hit_ff     <= 1'b0;
            status_ff  <= uvd_pkg::ST_DONE;
            removed_ff <= '0;
         end
         if (cmd.scan_read) begin
            scan_ff <= scan_ff + IDX_ONE;
         end
         if (cmd.set_status) begin
            status_ff <= cmd.status_code;
         end
         if (cmd.insert) begin
            count_ff <= count_ff + CNT_W'(1);
            if (ins_front) begin
               front_ff <= front_dec;
            end
         end
         if (cmd.rem_take) begin
            removed_ff <= ram_rd_data;
            count_ff   <= count_m1;
            if (mode_ff == uvd_pkg::MODE_REM_FRONT) begin
               front_ff <= front_inc;
            end
         end
         if (cmd.clear) begin
            front_ff <= '0;
            count_ff <= '0;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff  <= status_ff;
         rsp_removed_ff <= removed_ff;
         rsp_count_ff   <= uvd_pkg::COUNT_W'(count_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_entry_count   = rsp_count_ff;

   `UVD_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CAP_CNT,
      "stored count exceeds capacity")
   `UVD_ASSERT_IMPLY(a_write_not_full, clock, reset, ram_we, count_ff < CAP_CNT,
      "entry written into a full ring")
   `UVD_ASSERT_IMPLY(a_take_not_empty, clock, reset, cmd.rem_take, count_ff != '0,
      "remove taken from an empty ring")
   `UVD_ASSERT_IMPLY(a_scan_in_range, clock, reset, cmd.scan_read,
      CNT_W'(scan_ff) < count_ff, "scan reads beyond the stored entries")

endmodule

`default_nettype wire

[hw/rtl/unique_value_deque_top.sv]
// Unique value deque: a bounded ring of CAPACITY signed 32-bit values that can be
// pushed or popped at either end and refuses duplicate values. One request word
// (mode, value) gives exactly one response word (status, removed_value,
// entry_count). Requests are handled one at a time; the response sits in an
// output register so that a new request is taken while it waits. An insert into
// a non-empty deque first reads every stored entry once from the single read
// port of the entry RAM to look for the value, whether it then stores the value
// or refuses it as a duplicate or for a full ring; an insert into an empty deque
// skips this scan. A slow response sink adds its own wait. The entry RAM needs no
// clearing pass after reset: only occupied slots are ever read.
`default_nettype none

module unique_value_deque_top #(
   parameter int CAPACITY = 16
) (
   input wire logic   clock,
   input wire logic   reset,
   uvd_req_if.sink    req_bus,
   uvd_rsp_if.source  rsp_bus
);

   uvd_pkg::uvd_cmd_type  cmd;
   uvd_pkg::uvd_stat_type stat;

   logic [uvd_pkg::VALUE_W-1:0] rsp_removed;

   // Sequence each request: decode, scan for duplicates, write or read, respond.
   uvd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold the ring pointers, the entry RAM and the response register.
   uvd_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_mode          (req_bus.mode),
      .req_value         (req_bus.value),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_ready         (rsp_bus.ready),
      .rsp_valid         (rsp_bus.valid),
      .rsp_status        (rsp_bus.status),
      .rsp_removed_value (rsp_removed),
      .rsp_entry_count   (rsp_bus.entry_count)
   );

   assign rsp_bus.removed_value = rsp_removed;

endmodule

`default_nettype wire
